FILE: sv/modbus_rtu_read_transaction_top_defines.svh
// Assertion macros for the Modbus RTU read transaction block.
// Included by the port checker; expects i_clk and i_rst_n in scope.
`ifndef MODBUS_RTU_READ_TRANSACTION_TOP_DEFINES_SVH
`define MODBUS_RTU_READ_TRANSACTION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MBRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MBRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mbrd_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU read block.
// No dependencies; used by the top level, the output sequencer and the checker.
package mbrd_pkg;

    localparam int RX_DEPTH_DEF = 128;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;

    typedef logic [2:0] t_action;
    localparam t_action ACT_REQUEST = 3'd0;
    localparam t_action ACT_TX_DONE = 3'd1;
    localparam t_action ACT_RX_BYTE = 3'd2;
    localparam t_action ACT_TICK    = 3'd3;
    localparam t_action ACT_READ    = 3'd4;
    localparam t_action ACT_ACK     = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX,
        PH_RX,
        PH_DONE,
        PH_ERR,
        PH_FAULT
    } t_phase;

    typedef enum logic [1:0] {
        FLT_NONE,
        FLT_TX_TIMEOUT,
        FLT_RX_TIMEOUT,
        FLT_FRAME
    } t_fault;

    // Status of one accepted item, handed from the step logic to the sequencer
    typedef struct packed {
        logic       frame;
        logic       busy;
        t_phase     phase;
        t_fault     fault;
        logic [7:0] count;
        logic [7:0] rdata;
    } t_result;

    // One byte of the Modbus CRC-16 (reflected 0xA001)
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/mbrd_out_seq.sv
// Output stage of the Modbus RTU read block: holds one result and plays out
// the 8-byte request frame, folding its CRC one byte per beat. Uses mbrd_pkg.
module mbrd_out_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  mbrd_pkg::t_result i_load,
    output logic              o_load_ready,
    input  logic [7:0]        i_dev_addr,
    input  logic [15:0]       i_reg_start,
    input  logic [6:0]        i_reg_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_data,
    output logic              o_last,
    output logic [2:0]        o_phase,
    output logic [1:0]        o_fault_kind,
    output logic              o_busy_reject,
    output logic [7:0]        o_read_data,
    output logic [7:0]        o_received_count
);

    localparam logic [2:0] BEAT_ADDR     = 3'd0;
    localparam logic [2:0] BEAT_FUNC     = 3'd1;
    localparam logic [2:0] BEAT_START_HI = 3'd2;
    localparam logic [2:0] BEAT_START_LO = 3'd3;
    localparam logic [2:0] BEAT_COUNT_HI = 3'd4;
    localparam logic [2:0] BEAT_COUNT_LO = 3'd5;
    localparam logic [2:0] BEAT_CRC_LO   = 3'd6;
    localparam logic [2:0] BEAT_CRC_HI   = 3'd7;

    logic              r_valid;
    mbrd_pkg::t_result r_res;
    logic [2:0]        r_beat;
    logic [15:0]       r_crc;
    logic [7:0]        beat_byte;
    logic              last;
    logic              xfer;

    // Select the frame byte for the current beat
    always_comb begin
        unique case (r_beat)
            BEAT_ADDR:     beat_byte = i_dev_addr;
            BEAT_FUNC:     beat_byte = mbrd_pkg::FUNC_READ_INPUT;
            BEAT_START_HI: beat_byte = i_reg_start[15:8];
            BEAT_START_LO: beat_byte = i_reg_start[7:0];
            BEAT_COUNT_HI: beat_byte = 8'h00;   // count is at most 7 bits
            BEAT_COUNT_LO: beat_byte = {1'b0, i_reg_count};
            BEAT_CRC_LO:   beat_byte = r_crc[7:0];
            BEAT_CRC_HI:   beat_byte = r_crc[15:8];
            default:       beat_byte = 8'h00;
        endcase
    end

    assign last         = !r_res.frame || (r_beat == BEAT_CRC_HI);
    assign xfer         = r_valid && !i_stall;
    assign o_load_ready = !r_valid || (xfer && last);

    // Hold the result until its last beat transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    // Load a new result, or advance the frame beat and its CRC
    always_ff @(posedge i_clk) begin
        if (o_load_ready) begin
            r_res  <= i_load;
            r_beat <= BEAT_ADDR;
            r_crc  <= mbrd_pkg::CRC_INIT;
        end else if (xfer) begin
            r_beat <= r_beat + 3'd1;
            if (r_beat < BEAT_CRC_LO) begin
                r_crc <= mbrd_pkg::crc16_byte(r_crc, beat_byte);
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_tx_valid       = r_res.frame;
    assign o_tx_data        = r_res.frame ? beat_byte : 8'h00;
    assign o_last           = last;
    assign o_phase          = r_res.phase;
    assign o_fault_kind     = r_res.fault;
    assign o_busy_reject    = r_res.busy;
    assign o_read_data      = r_res.rdata;
    assign o_received_count = r_res.count;

endmodule

FILE: sv/modbus_rtu_read_transaction_top.sv
// Top level of the Modbus RTU function-04 read master.
// Depends on mbrd_pkg and mbrd_out_seq.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one event per transfer: request,
//   transmit done, received byte, millisecond tick, buffer read or acknowledge.
//   Output channel (o_valid / i_stall) returns one status result per event,
//   or eight results (the request frame, tx bytes in wire order) for a
//   request that is not refused as busy; o_last marks the final one.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
//   which the user must write only while the block is idle; the block does not enforce this.
// Pipeline and throughput:
//   One event is taken per cycle while o_stall is low. Its result is registered
//   first in the step register, together with the response memory read, and
//   then in the output register. A request occupies the output for eight
//   beats; the two-entry path (step register plus output register) lets one
//   more event be taken while results wait.
// Reset: control state and configuration return to defaults; the response
//   memory is not cleared and entries are read only once written.
// Stall: results hold on the output; once both registers are full o_stall
//   rises, combinationally from i_stall.
module modbus_rtu_read_transaction_top #(
    parameter int RX_DEPTH = mbrd_pkg::RX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_rx_data,
    input  logic [6:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_data,
    output logic        o_last,
    output logic [2:0]  o_phase,
    output logic [1:0]  o_fault_kind,
    output logic        o_busy_reject,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_received_count
);

    localparam int CW   = $clog2(RX_DEPTH + 1);
    localparam int AW   = $clog2(RX_DEPTH);
    localparam int CMPW = (CW > 9) ? CW + 1 : 10;

    localparam logic [2:0] CFG_DEV_ADDR  = 3'd0;
    localparam logic [2:0] CFG_REG_START = 3'd1;
    localparam logic [2:0] CFG_REG_COUNT = 3'd2;
    localparam logic [2:0] CFG_TX_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_RX_LIMIT  = 3'd4;

    // Configuration
    logic [7:0]  r_dev_addr;
    logic [15:0] r_reg_start;
    logic [6:0]  r_reg_count;
    logic [15:0] r_tx_limit;
    logic [15:0] r_rx_limit;

    // Transaction state
    mbrd_pkg::t_phase r_phase, n_phase;
    mbrd_pkg::t_fault r_fault, n_fault;
    logic [15:0]      r_tick, n_tick;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [8:0]       r_exp, n_exp;
    logic [15:0]      r_crc, n_crc;

    // Response memory and its registered read port
    logic [7:0] r_store [RX_DEPTH];
    logic [7:0] r_a_rdata;

    // Step register (first of the two result slots)
    logic              r_a_valid;
    mbrd_pkg::t_result r_a_res;
    logic              r_a_rd_en;
    mbrd_pkg::t_result a_res;
    mbrd_pkg::t_result res_d;

    logic            accept;
    logic            seq_ready;
    logic            busy_now;
    logic            store_we;
    logic            rd_en;
    logic            frame;
    logic            req_busy;
    logic [15:0]     crc_next;
    logic [CW-1:0]   cnt_inc;
    logic [8:0]      exp_byte;
    logic [8:0]      exp_eff;
    logic [15:0]     tick_inc;
    logic            rx_full;
    logic            rx_len_hit;
    logic            rx_len_over;
    logic            rx_end;
    logic            tx_tmo;
    logic            rx_tmo;
    logic [CMPW-1:0] idx_ext;

    assign o_stall = r_a_valid && !seq_ready;
    assign accept  = i_valid && !o_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= 8'd1;
            r_reg_start <= 16'd0;
            r_reg_count <= 7'd40;
            r_tx_limit  <= 16'd100;
            r_rx_limit  <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEV_ADDR:  r_dev_addr  <= i_cfg_data[7:0];
                CFG_REG_START: r_reg_start <= i_cfg_data;
                CFG_REG_COUNT: r_reg_count <= i_cfg_data[6:0];
                CFG_TX_LIMIT:  r_tx_limit  <= i_cfg_data;
                CFG_RX_LIMIT:  r_rx_limit  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Shared conditions for the step
    always_comb begin
        req_busy    = (r_phase == mbrd_pkg::PH_TX) || (r_phase == mbrd_pkg::PH_RX);
        crc_next    = mbrd_pkg::crc16_byte(r_crc, i_rx_data);
        cnt_inc     = CW'(r_cnt + 1'b1);
        exp_byte    = 9'd5 + {1'b0, i_rx_data};
        rx_full     = CMPW'(r_cnt) >= CMPW'(RX_DEPTH);
        rx_len_hit  = (cnt_inc == CW'(3));
        rx_len_over = rx_len_hit && (CMPW'(exp_byte) > CMPW'(RX_DEPTH));
        exp_eff     = rx_len_hit ? exp_byte : r_exp;
        rx_end      = (exp_eff != 9'd0) && (CMPW'(cnt_inc) >= CMPW'(exp_eff));
        tick_inc    = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
        tx_tmo      = tick_inc > r_tx_limit;
        rx_tmo      = tick_inc > r_rx_limit;
        idx_ext     = CMPW'(i_read_index);
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (i_action)
            mbrd_pkg::ACT_REQUEST: begin
                if (!req_busy) n_phase = mbrd_pkg::PH_TX;
            end
            mbrd_pkg::ACT_TX_DONE: begin
                if (r_phase == mbrd_pkg::PH_TX) n_phase = mbrd_pkg::PH_RX;
            end
            mbrd_pkg::ACT_RX_BYTE: begin
                if (r_phase == mbrd_pkg::PH_RX) begin
                    if (rx_full || rx_len_over) begin
                        n_phase = mbrd_pkg::PH_ERR;
                    end else if (rx_end) begin
                        n_phase = (crc_next == 16'd0) ? mbrd_pkg::PH_DONE : mbrd_pkg::PH_ERR;
                    end
                end
            end
            mbrd_pkg::ACT_TICK: begin
                if ((r_phase == mbrd_pkg::PH_TX && tx_tmo) ||
                    (r_phase == mbrd_pkg::PH_RX && rx_tmo) ||
                    (r_phase == mbrd_pkg::PH_ERR)) begin
                    n_phase = mbrd_pkg::PH_FAULT;
                end
            end
            mbrd_pkg::ACT_ACK: begin
                if (r_phase == mbrd_pkg::PH_DONE) n_phase = mbrd_pkg::PH_IDLE;
            end
            default: ;
        endcase
    end

    // Counters, CRC, fault code, memory strobes and result flags
    always_comb begin
        n_fault  = r_fault;
        n_tick   = r_tick;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_crc    = r_crc;
        store_we = 1'b0;
        rd_en    = 1'b0;
        frame    = 1'b0;
        busy_now = 1'b0;
        unique case (i_action)
            mbrd_pkg::ACT_REQUEST: begin
                if (req_busy) begin
                    busy_now = 1'b1;
                end else begin
                    frame   = 1'b1;
                    n_cnt   = '0;
                    n_exp   = 9'd0;
                    n_crc   = mbrd_pkg::CRC_INIT;
                    n_tick  = 16'd0;
                    n_fault = mbrd_pkg::FLT_NONE;
                end
            end
            mbrd_pkg::ACT_TX_DONE: begin
                if (r_phase == mbrd_pkg::PH_TX) n_tick = 16'd0;
            end
            mbrd_pkg::ACT_RX_BYTE: begin
                if (r_phase == mbrd_pkg::PH_RX) begin
                    if (rx_full) begin
                        n_fault = mbrd_pkg::FLT_FRAME;
                    end else begin
                        store_we = 1'b1;
                        n_cnt    = cnt_inc;
                        n_crc    = crc_next;
                        n_exp    = exp_eff;
                        if (rx_len_over || (rx_end && crc_next != 16'd0)) begin
                            n_fault = mbrd_pkg::FLT_FRAME;
                        end
                    end
                end
            end
            mbrd_pkg::ACT_TICK: begin
                priority if (r_phase == mbrd_pkg::PH_TX) begin
                    n_tick = tick_inc;
                    if (tx_tmo) n_fault = mbrd_pkg::FLT_TX_TIMEOUT;
                end else if (r_phase == mbrd_pkg::PH_RX) begin
                    n_tick = tick_inc;
                    if (rx_tmo) n_fault = mbrd_pkg::FLT_RX_TIMEOUT;
                end else if (r_phase != mbrd_pkg::PH_ERR) begin
                    n_tick = 16'd0;
                end
            end
            mbrd_pkg::ACT_READ: begin
                rd_en = (CMPW'(i_read_index) < CMPW'(r_cnt)) &&
                        (CMPW'(i_read_index) < CMPW'(RX_DEPTH));
            end
            default: ;
        endcase

        res_d.frame = frame;
        res_d.busy  = busy_now;
        res_d.phase = n_phase;
        res_d.fault = n_fault;
        res_d.count = 8'(n_cnt);
        res_d.rdata = 8'h00;
    end

    // Commit the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mbrd_pkg::PH_IDLE;
            r_fault <= mbrd_pkg::FLT_NONE;
            r_tick  <= 16'd0;
            r_cnt   <= '0;
            r_exp   <= 9'd0;
            r_crc   <= mbrd_pkg::CRC_INIT;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fault <= n_fault;
            r_tick  <= n_tick;
            r_cnt   <= n_cnt;
            r_exp   <= n_exp;
            r_crc   <= n_crc;
        end
    end

    // Response memory: write received bytes, registered read for buffer reads
    always_ff @(posedge i_clk) begin
        if (accept && store_we) begin
            r_store[r_cnt[AW-1:0]] <= i_rx_data;
        end
        if (accept && rd_en) begin
            r_a_rdata <= r_store[idx_ext[AW-1:0]];
        end
    end

    // Step register: fill on transfer, drain into the output sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (seq_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_res   <= res_d;
            r_a_rd_en <= rd_en;
        end
    end

    // Merge the memory read data into the result
    always_comb begin
        a_res       = r_a_res;
        a_res.rdata = r_a_rd_en ? r_a_rdata : 8'h00;
    end

    mbrd_out_seq u_out_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load_valid     (r_a_valid),
        .i_load           (a_res),
        .o_load_ready     (seq_ready),
        .i_dev_addr       (r_dev_addr),
        .i_reg_start      (r_reg_start),
        .i_reg_count      (r_reg_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tx_valid       (o_tx_valid),
        .o_tx_data        (o_tx_data),
        .o_last           (o_last),
        .o_phase          (o_phase),
        .o_fault_kind     (o_fault_kind),
        .o_busy_reject    (o_busy_reject),
        .o_read_data      (o_read_data),
        .o_received_count (o_received_count)
    );

endmodule

FILE: sv/mbrd_checker.sv
// Port-level checker for the Modbus RTU read block, bound to the top level.
// Depends on mbrd_pkg and modbus_rtu_read_transaction_top_defines.svh.
`include "modbus_rtu_read_transaction_top_defines.svh"

module mbrd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_data,
    input logic       o_last,
    input logic [2:0] o_phase,
    input logic [1:0] o_fault_kind,
    input logic       o_busy_reject,
    input logic [7:0] o_read_data,
    input logic [7:0] o_received_count
);

    logic [31:0] out_word;
    logic        out_wait;
    logic        frame_beat;
    logic        frame_mid;
    logic        frame_ok;
    logic        busy_beat;
    logic        busy_ok;

    // Pack the result fields so a stalled result is checked in one compare
    assign out_word   = {o_tx_valid, o_tx_data, o_last, o_phase, o_fault_kind, o_busy_reject,
                         o_read_data, o_received_count};
    assign out_wait   = o_valid && i_stall;
    assign frame_beat = o_valid && o_tx_valid;
    assign frame_mid  = frame_beat && !i_stall && !o_last;
    assign frame_ok   = (o_phase == mbrd_pkg::PH_TX) && (o_fault_kind == mbrd_pkg::FLT_NONE) &&
                        !o_busy_reject && (o_received_count == 8'd0) && (o_read_data == 8'd0);
    assign busy_beat  = o_valid && o_busy_reject;
    assign busy_ok    = !o_tx_valid && o_last &&
                        ((o_phase == mbrd_pkg::PH_TX) || (o_phase == mbrd_pkg::PH_RX));

    // A stalled result stays on the port unchanged
    `MBRD_ASSERT_NEXT(a_out_hold, out_wait, o_valid && $stable(out_word), "stalled result changed")

    // Frame bytes carry the fresh transmit status
    `MBRD_ASSERT_NOW(a_frame_status, frame_beat, frame_ok, "frame byte with wrong status")

    // A refused request is a single status result in transmit or receive
    `MBRD_ASSERT_NOW(a_busy_shape, busy_beat, busy_ok, "malformed busy result")

    // Frame beats follow each other without a gap
    `MBRD_ASSERT_NEXT(a_frame_burst, frame_mid, frame_beat, "gap inside request frame")

endmodule

bind modbus_rtu_read_transaction_top mbrd_checker u_mbrd_checker (.*);
